// ===== src/ulj_pkg.sv =====
// ulj_pkg: shared types, widths and codes of the udp loss and jitter tracker
// no dependencies; imported by every module of the block
package ulj_pkg;

    // field widths
    localparam int SEQ_W      = 64;
    localparam int TALLY_W    = 64;
    localparam int JITTER_W   = 48;
    localparam int TRANSIT_W  = 48;
    localparam int SECONDS_W  = 32;
    localparam int MICROS_W   = 20;
    localparam int LENGTH_W   = 16;

    // seconds * 1e6 fits in 52 bits, plus micros in 53
    localparam int PROD_W     = SECONDS_W + MICROS_W;
    localparam int STAMP_W    = PROD_W + 1;

    localparam logic [MICROS_W-1:0] MICROS_PER_SEC = 20'd1000000;

    // jitter smoothing: move by 1/16 of the difference
    localparam int SMOOTH_SHIFT = 4;
    localparam int JITTER_FRACTION_BITS_DEF = 8;

    // action on the loss tally decided by the sequence stage
    typedef enum logic [1:0] {
        LOSS_KEEP,
        LOSS_ADD,
        LOSS_DEC
    } loss_op_t;

    // one received datagram header
    typedef struct packed {
        logic [SECONDS_W-1:0] sent_seconds;
        logic [MICROS_W-1:0]  sent_micros;
        logic [SEQ_W-1:0]     count_word;
        logic [SECONDS_W-1:0] arrival_seconds;
        logic [MICROS_W-1:0]  arrival_micros;
        logic [LENGTH_W-1:0]  length_bytes;
        logic                 running;
    } hdr_t;

    // one statistics result
    typedef struct packed {
        logic                 counted;
        logic [SEQ_W-1:0]     highest_sequence;
        logic [TALLY_W-1:0]   lost_packets;
        logic [TALLY_W-1:0]   reordered_packets;
        logic [JITTER_W-1:0]  jitter_value;
        logic [TALLY_W-1:0]   total_bytes;
    } stat_t;

    // header after transit time is known
    typedef struct packed {
        logic [TRANSIT_W-1:0] transit;
        logic [SEQ_W-1:0]     seq;
        logic [LENGTH_W-1:0]  len;
        logic                 running;
    } transit_t;

    // header after sequence and byte accounting
    typedef struct packed {
        logic                 running;
        logic [TRANSIT_W-1:0] delta;
        loss_op_t             loss_op;
        logic [TALLY_W-1:0]   gap;
        logic [SEQ_W-1:0]     top;
        logic [TALLY_W-1:0]   reorder;
        logic [TALLY_W-1:0]   bytes;
    } front_t;

endpackage

// ===== src/ulj_transit.sv =====
// ulj_transit: input register and transit time pipeline (multiply, add, abs diff)
// depends on ulj_pkg
module ulj_transit
    import ulj_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wide_counters,
    input  logic     in_valid,
    output logic     in_ready,
    input  hdr_t     in_hdr,
    output logic     out_valid,
    input  logic     out_ready,
    output transit_t out_item
);

    typedef struct packed {
        logic [PROD_W-1:0]   prod_sent;
        logic [PROD_W-1:0]   prod_arr;
        logic [MICROS_W-1:0] sent_micros;
        logic [MICROS_W-1:0] arrival_micros;
        logic [SEQ_W-1:0]    seq;
        logic [LENGTH_W-1:0] len;
        logic                running;
    } prod_t;

    typedef struct packed {
        logic [STAMP_W-1:0]  t_sent;
        logic [STAMP_W-1:0]  t_arr;
        logic [SEQ_W-1:0]    seq;
        logic [LENGTH_W-1:0] len;
        logic                running;
    } stamp_t;

    logic     s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic     s1_valid_next, s2_valid_next, s3_valid_next, s4_valid_next;
    logic     s1_ready, s2_ready, s3_ready, s4_ready;
    hdr_t     s1_reg;
    prod_t    s2_reg, s2_next;
    stamp_t   s3_reg, s3_next;
    transit_t s4_reg, s4_next;

    logic [STAMP_W-1:0] fwd_diff, rev_diff;
    logic [STAMP_W-1:0] abs_transit;

    // per stage ready: a stage takes data when empty or when it drains
    assign s4_ready = !s4_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_comb
    begin
        s1_valid_next = s1_ready ? in_valid     : s1_valid_reg;
        s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
        s3_valid_next = s3_ready ? s2_valid_reg : s3_valid_reg;
        s4_valid_next = s4_ready ? s3_valid_reg : s4_valid_reg;
    end

    // seconds to microseconds and sequence field selection
    always_comb
    begin
        s2_next.prod_sent      = PROD_W'(s1_reg.sent_seconds) * PROD_W'(MICROS_PER_SEC);
        s2_next.prod_arr       = PROD_W'(s1_reg.arrival_seconds) * PROD_W'(MICROS_PER_SEC);
        s2_next.sent_micros    = s1_reg.sent_micros;
        s2_next.arrival_micros = s1_reg.arrival_micros;
        s2_next.seq            = wide_counters ? s1_reg.count_word
                                               : {32'd0, s1_reg.count_word[63:32]};
        s2_next.len            = s1_reg.length_bytes;
        s2_next.running        = s1_reg.running;
    end

    // full timestamps in microseconds
    always_comb
    begin
        s3_next.t_sent  = STAMP_W'(s2_reg.prod_sent) + STAMP_W'(s2_reg.sent_micros);
        s3_next.t_arr   = STAMP_W'(s2_reg.prod_arr) + STAMP_W'(s2_reg.arrival_micros);
        s3_next.seq     = s2_reg.seq;
        s3_next.len     = s2_reg.len;
        s3_next.running = s2_reg.running;
    end

    // absolute transit, saturated to 48 bits
    assign fwd_diff    = s3_reg.t_arr - s3_reg.t_sent;
    assign rev_diff    = s3_reg.t_sent - s3_reg.t_arr;
    assign abs_transit = (s3_reg.t_arr >= s3_reg.t_sent) ? fwd_diff : rev_diff;

    always_comb
    begin
        if (abs_transit[STAMP_W-1:TRANSIT_W] != '0)
        begin
            s4_next.transit = '1;
        end
        else
        begin
            s4_next.transit = abs_transit[TRANSIT_W-1:0];
        end
        s4_next.seq     = s3_reg.seq;
        s4_next.len     = s3_reg.len;
        s4_next.running = s3_reg.running;
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_reg <= in_hdr;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_reg <= s3_next;
        end
        if (s4_ready && s3_valid_reg)
        begin
            s4_reg <= s4_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_item  = s4_reg;

endmodule

// ===== src/ulj_front.sv =====
// ulj_front: sequence tracking, byte tally and transit delta stage
// depends on ulj_pkg
module ulj_front
    import ulj_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  transit_t in_item,
    output logic     out_valid,
    input  logic     out_ready,
    output front_t   out_item
);

    logic                 valid_reg, valid_next;
    front_t               item_reg, item_next;
    logic [SEQ_W-1:0]     top_reg, top_next;
    logic [TALLY_W-1:0]   reorder_reg, reorder_next;
    logic [TALLY_W-1:0]   bytes_reg, bytes_next;
    logic [TRANSIT_W-1:0] last_transit_reg, last_transit_next;

    logic                 fire;
    logic                 first;
    logic                 ahead;
    logic [TALLY_W-1:0]   gap;
    logic [TRANSIT_W-1:0] delta;

    assign in_ready   = !valid_reg || out_ready;
    assign fire       = in_valid && in_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    // first counted packet: nothing added to the byte tally yet
    assign first = (bytes_reg == '0);

    // ahead when seq >= top + 1 mod 2^64; gap is seq - 1 - top
    assign ahead = (&top_reg) || (in_item.seq > top_reg);
    assign gap   = in_item.seq + ~top_reg;

    // transit change against the previous packet
    always_comb
    begin
        if (first)
        begin
            delta = '0;
        end
        else if (in_item.transit >= last_transit_reg)
        begin
            delta = in_item.transit - last_transit_reg;
        end
        else
        begin
            delta = last_transit_reg - in_item.transit;
        end
    end

    // state update and outgoing transaction
    always_comb
    begin
        top_next          = top_reg;
        reorder_next      = reorder_reg;
        bytes_next        = bytes_reg;
        last_transit_next = last_transit_reg;
        item_next.loss_op = LOSS_KEEP;
        if (in_item.running)
        begin
            bytes_next        = bytes_reg + TALLY_W'(in_item.len);
            last_transit_next = in_item.transit;
            if (ahead)
            begin
                top_next          = in_item.seq;
                item_next.loss_op = LOSS_ADD;
            end
            else
            begin
                reorder_next      = reorder_reg + TALLY_W'(1);
                item_next.loss_op = LOSS_DEC;
            end
        end
        item_next.running = in_item.running;
        item_next.delta   = delta;
        item_next.gap     = gap;
        item_next.top     = top_next;
        item_next.reorder = reorder_next;
        item_next.bytes   = bytes_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= 1'b0;
            top_reg          <= '0;
            reorder_reg      <= '0;
            bytes_reg        <= '0;
            last_transit_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (fire)
            begin
                top_reg          <= top_next;
                reorder_reg      <= reorder_next;
                bytes_reg        <= bytes_next;
                last_transit_reg <= last_transit_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== src/ulj_accum.sv =====
// ulj_accum: loss tally and jitter smoothing, result register
// depends on ulj_pkg
module ulj_accum
    import ulj_pkg::*;
#(
    parameter int JITTER_FRACTION_BITS = JITTER_FRACTION_BITS_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  front_t in_item,
    output logic   out_valid,
    input  logic   out_ready,
    output stat_t  out_stat
);

    localparam int DFX_W  = JITTER_W + JITTER_FRACTION_BITS;
    localparam int BASE_W = JITTER_W + SMOOTH_SHIFT;
    localparam int SUM_W  = ((DFX_W > BASE_W) ? DFX_W : BASE_W) + 1;
    localparam logic [SUM_W-1:0] ROUND_UP = SUM_W'((1 << SMOOTH_SHIFT) - 1);

    logic                valid_reg, valid_next;
    stat_t               stat_reg, stat_next;
    logic [TALLY_W-1:0]  loss_reg, loss_next;
    logic [JITTER_W-1:0] jitter_reg, jitter_next;

    logic                fire;
    logic [DFX_W-1:0]    dfx;
    logic                below;
    logic [SUM_W-1:0]    sum;
    logic [SUM_W-1:0]    moved;

    assign in_ready   = !valid_reg || out_ready;
    assign fire       = in_valid && in_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    // loss tally: add the gap, or take one off floored at zero
    always_comb
    begin
        loss_next = loss_reg;
        if (in_item.running)
        begin
            case (in_item.loss_op)
                LOSS_ADD: loss_next = loss_reg + in_item.gap;
                LOSS_DEC: loss_next = loss_reg - TALLY_W'(loss_reg != '0);
                default:  loss_next = loss_reg;
            endcase
        end
    end

    // jitter: floor((15j + dfx) / 16), rounded up when moving down,
    // which equals j +/- truncated |dfx - j| / 16
    assign dfx   = DFX_W'(in_item.delta) << JITTER_FRACTION_BITS;
    assign below = (dfx < DFX_W'(jitter_reg));
    assign sum   = (SUM_W'(jitter_reg) << SMOOTH_SHIFT) - SUM_W'(jitter_reg)
                 + SUM_W'(dfx) + (below ? ROUND_UP : '0);
    assign moved = sum >> SMOOTH_SHIFT;

    always_comb
    begin
        jitter_next = jitter_reg;
        if (in_item.running)
        begin
            if (moved[SUM_W-1:JITTER_W] != '0)
            begin
                jitter_next = '1;
            end
            else
            begin
                jitter_next = moved[JITTER_W-1:0];
            end
        end
    end

    // result transaction
    always_comb
    begin
        stat_next.counted           = in_item.running;
        stat_next.highest_sequence  = in_item.top;
        stat_next.lost_packets      = loss_next;
        stat_next.reordered_packets = in_item.reorder;
        stat_next.jitter_value      = jitter_next;
        stat_next.total_bytes       = in_item.bytes;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            loss_reg   <= '0;
            jitter_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (fire)
            begin
                loss_reg   <= loss_next;
                jitter_reg <= jitter_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            stat_reg <= stat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stat  = stat_reg;

endmodule

// ===== src/udp_loss_jitter_tracker.sv =====
// udp_loss_jitter_tracker: top level, mode register and pipeline wiring
// depends on ulj_pkg, ulj_transit, ulj_front, ulj_accum
//
// Receive-side loss and jitter statistics for sequenced, time-stamped
// datagrams. Each header transaction on hdr (valid/ready) yields exactly one
// stat transaction carrying the updated counters, or the current ones with
// counted low when the header's running flag is clear.
// cfg_write_en writes cfg_write_data into the sequence mode register
// (1: 64-bit sequence, 0: upper 32 bits of count_word); write it only
// while no header is in flight.
// Throughput: one header per cycle while stat_ready is high. Every stage is
// a short registered step and all per-packet state (sequence, byte tally,
// last transit, loss, jitter) closes its loop within a single stage.
// Path: a header passes the input register, multiply, timestamp add,
// transit, sequence/bytes, then loss/jitter into the result register,
// where its stat result becomes valid.
// Stalls: each stage holds its transaction while the next one is full, so
// hdr_ready stays high as long as any stage ahead has room; with stat_ready
// low the pipeline fills and then hdr_ready drops.
// Reset clears all counters, the mode register and every stage valid flag.
module udp_loss_jitter_tracker
    import ulj_pkg::*;
#(
    parameter int JITTER_FRACTION_BITS = JITTER_FRACTION_BITS_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  hdr_valid,
    output logic  hdr_ready,
    input  hdr_t  hdr,
    output logic  stat_valid,
    input  logic  stat_ready,
    output stat_t stat,
    input  logic  cfg_write_en,
    input  logic  cfg_write_data
);

    logic     wide_counters_reg, wide_counters_next;
    logic     tr_valid, tr_ready;
    transit_t tr_item;
    logic     fr_valid, fr_ready;
    front_t   fr_item;

    // sequence mode register
    assign wide_counters_next = cfg_write_en ? cfg_write_data : wide_counters_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_counters_reg <= 1'b0;
        end
        else
        begin
            wide_counters_reg <= wide_counters_next;
        end
    end

    // timestamps to transit
    ulj_transit u_transit (
        .clk           (clk),
        .rst_n         (rst_n),
        .wide_counters (wide_counters_reg),
        .in_valid      (hdr_valid),
        .in_ready      (hdr_ready),
        .in_hdr        (hdr),
        .out_valid     (tr_valid),
        .out_ready     (tr_ready),
        .out_item      (tr_item)
    );

    // sequence, bytes and transit delta
    ulj_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tr_valid),
        .in_ready  (tr_ready),
        .in_item   (tr_item),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_item  (fr_item)
    );

    // loss and jitter, result register
    ulj_accum #(
        .JITTER_FRACTION_BITS (JITTER_FRACTION_BITS)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_item   (fr_item),
        .out_valid (stat_valid),
        .out_ready (stat_ready),
        .out_stat  (stat)
    );

endmodule

// ===== verif/udp_loss_jitter_tracker_test.sv =====
// udp_loss_jitter_tracker_test: self-checking bench for the loss and jitter tracker
// depends on ulj_pkg and udp_loss_jitter_tracker; a scoreboard class predicts each stat
module udp_loss_jitter_tracker_test;
    import ulj_pkg::*;

    localparam int RUN_LIMIT_CYCLES = 300000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int HOLD_AFTER_STATS = 300;

    // predicted tracker state and the stats still due from the block
    class tracker_scoreboard;
        localparam logic [63:0] FIELD48_MAX = 64'h0000_FFFF_FFFF_FFFF;
        localparam logic [63:0] USEC_PER_S  = 64'd1_000_000;

        bit          wide_seq;
        logic [63:0] top_seq;
        logic [63:0] loss_count;
        logic [63:0] late_count;
        logic [63:0] byte_count;
        logic [47:0] last_transit;
        logic [47:0] jitter_fx;
        stat_t       stats_due[$];
        int          mismatches;
        int          headers_noted;
        int          idle_noted;
        int          late_noted;
        int          gap_noted;
        int          clamp_noted;
        int          stats_checked;

        function new();
            wide_seq     = 1'b0;
            top_seq      = '0;
            loss_count   = '0;
            late_count   = '0;
            byte_count   = '0;
            last_transit = '0;
            jitter_fx    = '0;
        endfunction

        function int pending();
            return stats_due.size();
        endfunction

        // timestamp in whole microseconds
        function logic [63:0] stamp_us(logic [31:0] secs, logic [19:0] usecs);
            return 64'(secs) * USEC_PER_S + 64'(usecs);
        endfunction

        // update the tracker state for one accepted header and queue its stat
        function void note_header(hdr_t h);
            logic [63:0] seq;
            logic [63:0] next_seq;
            logic [63:0] t_sent;
            logic [63:0] t_arr;
            logic [63:0] transit;
            logic [63:0] delta;
            logic [63:0] scaled;
            logic [63:0] acc;
            bit          first;
            stat_t       want;
            headers_noted++;
            if (h.running) begin
                first = (byte_count == 64'd0);
                byte_count = byte_count + 64'(h.length_bytes);

                // sequence tracking
                seq = wide_seq ? h.count_word : {32'd0, h.count_word[63:32]};
                next_seq = top_seq + 64'd1;
                if (seq >= next_seq) begin
                    if (seq > next_seq) begin
                        loss_count = loss_count + (seq - 64'd1 - top_seq);
                        gap_noted++;
                    end
                    top_seq = seq;
                end
                else begin
                    late_count = late_count + 64'd1;
                    if (loss_count != 64'd0)
                        loss_count = loss_count - 64'd1;
                    late_noted++;
                end

                // transit time, clamped to 48 bits
                t_sent = stamp_us(h.sent_seconds, h.sent_micros);
                t_arr  = stamp_us(h.arrival_seconds, h.arrival_micros);
                transit = (t_arr >= t_sent) ? t_arr - t_sent : t_sent - t_arr;
                if (transit > FIELD48_MAX) begin
                    transit = FIELD48_MAX;
                    clamp_noted++;
                end

                // 1/16 running average of the transit difference
                if (first)
                    last_transit = transit[47:0];
                delta = (transit >= 64'(last_transit)) ? transit - 64'(last_transit)
                                                       : 64'(last_transit) - transit;
                last_transit = transit[47:0];
                scaled = delta << JITTER_FRACTION_BITS_DEF;
                acc = 64'(jitter_fx);
                if (scaled >= acc)
                    acc = acc + ((scaled - acc) >> SMOOTH_SHIFT);
                else
                    acc = acc - ((acc - scaled) >> SMOOTH_SHIFT);
                if (acc > FIELD48_MAX) begin
                    acc = FIELD48_MAX;
                    clamp_noted++;
                end
                jitter_fx = acc[47:0];
            end
            else begin
                idle_noted++;
            end

            want.counted           = h.running;
            want.highest_sequence  = top_seq;
            want.lost_packets      = loss_count;
            want.reordered_packets = late_count;
            want.jitter_value      = jitter_fx;
            want.total_bytes       = byte_count;
            stats_due.push_back(want);
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 100)
                $display("mismatch: %s", msg);
        endtask

        task check_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report($sformatf("stat %0d %s: got %h expected %h",
                                 stats_checked, name, got, want));
        endtask

        // compare one accepted stat with the oldest one due
        task check_stat(stat_t got);
            stat_t want;
            if (stats_due.size() == 0) begin
                report($sformatf("stat arrived with no header outstanding: %h", got));
                return;
            end
            want = stats_due.pop_front();
            check_field("counted", 64'(got.counted), 64'(want.counted));
            check_field("highest_sequence", got.highest_sequence, want.highest_sequence);
            check_field("lost_packets", got.lost_packets, want.lost_packets);
            check_field("reordered_packets", got.reordered_packets, want.reordered_packets);
            check_field("jitter_value", 64'(got.jitter_value), 64'(want.jitter_value));
            check_field("total_bytes", got.total_bytes, want.total_bytes);
            stats_checked++;
        endtask
    endclass

    logic  clk = 1'b0;
    logic  rst_n;
    logic  hdr_valid;
    logic  hdr_ready;
    hdr_t  hdr;
    logic  stat_valid;
    logic  stat_ready;
    stat_t stat;
    logic  cfg_write_en;
    logic  cfg_write_data;

    tracker_scoreboard board = new();
    int          stats_seen;
    int          mode_writes;
    logic [63:0] stream_seq;
    longint      stream_clock;
    longint      path_delay;
    int          delay_spread;

    udp_loss_jitter_tracker dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .hdr_valid      (hdr_valid),
        .hdr_ready      (hdr_ready),
        .hdr            (hdr),
        .stat_valid     (stat_valid),
        .stat_ready     (stat_ready),
        .stat           (stat),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // stat monitor
    always @(posedge clk)
    begin
        if (rst_n && stat_valid && stat_ready) begin
            board.check_stat(stat);
            stats_seen++;
        end
    end

    // stat sink: stall patterns plus one long hold-off
    initial
    begin : stat_sink
        int pattern;
        int span;
        int tick;
        int held;
        bit long_hold_done;
        long_hold_done = 1'b0;
        stat_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            pattern = $urandom_range(0, 3);
            span = $urandom_range(32, 256);
            for (tick = 0; tick < span; tick++) begin
                @(negedge clk);
                if (!long_hold_done && stats_seen >= HOLD_AFTER_STATS) begin
                    long_hold_done = 1'b1;
                    stat_ready <= 1'b0;
                    for (held = 0; held < LONG_HOLD_CYCLES; held++)
                        @(negedge clk);
                end
                case (pattern)
                    0:       stat_ready <= 1'b1;
                    1:       stat_ready <= ($urandom_range(0, 3) != 0);
                    2:       stat_ready <= ($urandom_range(0, 3) == 0);
                    default: stat_ready <= ((tick % 8) < 3);
                endcase
            end
        end
    end

    // drive one header and hold it until accepted; returns at a falling edge
    task automatic send_header(input hdr_t h);
        hdr <= h;
        hdr_valid <= 1'b1;
        do
            @(posedge clk);
        while (!hdr_ready);
        board.note_header(h);
        @(negedge clk);
    endtask

    // stop offering and wait until every stat due has come back
    task automatic drain();
        hdr_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // mode register write, block idle
    task automatic write_mode(input bit wide);
        cfg_write_en <= 1'b1;
        cfg_write_data <= wide;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        board.wide_seq = wide;
        mode_writes++;
    endtask

    function automatic hdr_t make_header(logic [31:0] s_sec, logic [19:0] s_us,
                                         logic [63:0] word, logic [31:0] a_sec,
                                         logic [19:0] a_us, logic [15:0] len,
                                         logic run);
        hdr_t h;
        h.sent_seconds    = s_sec;
        h.sent_micros     = s_us;
        h.count_word      = word;
        h.arrival_seconds = a_sec;
        h.arrival_micros  = a_us;
        h.length_bytes    = len;
        h.running         = run;
        return h;
    endfunction

    // keep the generated stream just above the tracked highest sequence
    function automatic void follow_top();
        stream_seq = board.wide_seq ? board.top_seq : {32'd0, board.top_seq[31:0]};
    endfunction

    // well-formed stream: mostly in order, some gaps, late and repeated packets
    function automatic hdr_t stream_header();
        hdr_t        h;
        logic [63:0] seq;
        longint      arrive;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 70 || (pick < 82 && stream_seq > 64'hFFFF_FFFF_FFFF_FFF0)) begin
            stream_seq = stream_seq + 64'd1;
            seq = stream_seq;
        end
        else if (pick < 82) begin
            stream_seq = stream_seq + 64'($urandom_range(2, 6));
            seq = stream_seq;
        end
        else if (pick < 94 && stream_seq >= 64'd5) begin
            seq = stream_seq - 64'($urandom_range(1, 4));
        end
        else begin
            seq = stream_seq;
        end

        stream_clock = stream_clock + longint'($urandom_range(50, 20000));
        arrive = stream_clock + path_delay + longint'($urandom_range(0, delay_spread));

        h.sent_seconds    = 32'(stream_clock / 1000000);
        h.sent_micros     = 20'(stream_clock % 1000000);
        h.arrival_seconds = 32'(arrive / 1000000);
        h.arrival_micros  = 20'(arrive % 1000000);
        h.count_word      = board.wide_seq ? seq : {seq[31:0], 32'($urandom())};
        h.length_bytes    = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535))
                                                        : 16'($urandom_range(40, 1500));
        h.running         = ($urandom_range(0, 19) != 0);
        return h;
    endfunction

    // unrelated header with random content
    function automatic hdr_t noise_header();
        hdr_t h;
        h.sent_seconds    = $urandom();
        h.sent_micros     = 20'($urandom_range(0, 999999));
        h.count_word      = board.wide_seq ? {32'd0, 32'($urandom())}
                                           : {32'($urandom()), 32'($urandom())};
        h.arrival_seconds = $urandom();
        h.arrival_micros  = 20'($urandom_range(0, 999999));
        h.length_bytes    = 16'($urandom_range(1, 65535));
        h.running         = 1'($urandom_range(0, 1));
        return h;
    endfunction

    // one random phase: bursty traffic at a fixed mode, then drained
    task automatic run_phase(input bit wide, input int items, input bit near_wrap);
        int   burst;
        int   gap;
        int   n;
        bit   noisy;
        hdr_t h;
        write_mode(wide);
        follow_top();
        if (near_wrap)
            stream_seq = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(50, 300));
        stream_clock = longint'($urandom_range(1000, 32'hF000_0000)) * 1000000;
        path_delay   = longint'($urandom_range(0, 600000)) - 100000;
        delay_spread = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2000000)
                                                   : $urandom_range(0, 5000);
        burst = $urandom_range(1, 24);
        for (n = 0; n < items; n++) begin
            noisy = ($urandom_range(0, 99) < 8);
            h = noisy ? noise_header() : stream_header();
            send_header(h);
            if (noisy)
                follow_top();
            burst--;
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
                if (gap != 0) begin
                    hdr_valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
        end
        drain();
    endtask

    // stimulus
    initial
    begin : stimulus
        hdr_t plan[$];
        rst_n = 1'b0;
        hdr_valid = 1'b0;
        hdr = '0;
        cfg_write_en = 1'b0;
        cfg_write_data = 1'b0;
        stats_seen = 0;
        mode_writes = 0;
        stream_seq = '0;
        stream_clock = 0;
        path_delay = 0;
        delay_spread = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed, 32-bit sequence field
        write_mode(1'b0);
        // idle packet before anything counted
        plan.push_back(make_header(10, 0, {32'd7, 32'd0}, 10, 500, 60, 1'b0));
        // first packet of zero length, so the next is first again and late at zero loss
        plan.push_back(make_header(100, 0, {32'd1, 32'hFFFF_FFFF}, 100, 5000, 0, 1'b1));
        plan.push_back(make_header(100, 1000, {32'd1, 32'd0}, 100, 9000, 100, 1'b1));
        plan.push_back(make_header(100, 2000, {32'd2, 32'd0}, 100, 9500, 1, 1'b1));
        // gap, then a late packet and a repeat of the highest
        plan.push_back(make_header(100, 3000, {32'd10, 32'd0}, 100, 30000, 1500, 1'b1));
        plan.push_back(make_header(100, 4000, {32'd5, 32'd0}, 100, 12000, 1500, 1'b1));
        plan.push_back(make_header(100, 5000, {32'd10, 32'd0}, 100, 13000, 64, 1'b1));
        // microseconds beyond one second used as given
        plan.push_back(make_header(101, 20'hFFFFF, {32'd11, 32'd0}, 102, 20'hFFFFF, 64, 1'b1));
        // arrival earlier than send time
        plan.push_back(make_header(32'hFFFF_FFFF, 999999, {32'd12, 32'd0},
                                   32'hFFFF_FFFE, 0, 64, 1'b1));
        // transit beyond 48 bits, jitter clamps
        plan.push_back(make_header(0, 0, {32'd13, 32'd0}, 32'hFFFF_FFFF, 999999, 64, 1'b1));
        plan.push_back(make_header(0, 0, {32'd14, 32'd0}, 0, 0, 64, 1'b1));
        // all ones while not running
        plan.push_back(make_header(32'hFFFF_FFFF, 20'hFFFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                                   32'hFFFF_FFFF, 20'hFFFFF, 16'hFFFF, 1'b0));
        // largest 32-bit sequence and length, then a late zero
        plan.push_back(make_header(5, 0, {32'hFFFF_FFFF, 32'd0}, 5, 100, 16'hFFFF, 1'b1));
        plan.push_back(make_header(5, 10, {32'd0, 32'hFFFF_FFFF}, 5, 20, 40, 1'b1));
        foreach (plan[i])
            send_header(plan[i]);
        drain();

        // directed, full 64-bit sequence: loss wraps, next sequence wraps to zero
        write_mode(1'b1);
        plan.delete();
        plan.push_back(make_header(6, 0, 64'hFFFF_FFFF_FFFF_FFFF, 6, 300, 100, 1'b1));
        plan.push_back(make_header(6, 100, 64'd0, 6, 400, 100, 1'b1));
        plan.push_back(make_header(6, 200, 64'h8000_0000_0000_0000, 6, 500, 100, 1'b1));
        plan.push_back(make_header(6, 300, 64'd1, 6, 600, 100, 1'b1));
        plan.push_back(make_header(6, 400, 64'hFFFF_FFFF_FFFF_FFFF, 6, 700, 100, 1'b1));
        plan.push_back(make_header(6, 500, 64'd0, 6, 800, 100, 1'b1));
        plan.push_back(make_header(6, 600, 64'd1, 6, 900, 100, 1'b1));
        foreach (plan[i])
            send_header(plan[i]);
        drain();

        // random phases, the last one wrapping the 64-bit sequence
        run_phase(1'b0, 400, 1'b0);
        run_phase(1'b1, 400, 1'b0);
        run_phase(1'b0, 400, 1'b0);
        run_phase(1'b1, 400, 1'b1);

        // let any stray stat show up
        repeat (10) @(posedge clk);

        $display("covered %0d headers (%0d not running) over %0d mode writes, %0d stats checked",
                 board.headers_noted, board.idle_noted, mode_writes, board.stats_checked);
        $display("late packets %0d, sequence gaps %0d, clamped values %0d, mismatches %0d",
                 board.late_noted, board.gap_noted, board.clamp_noted, board.mismatches);
        if (board.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // run limit
    initial
    begin : watchdog
        #(RUN_LIMIT_CYCLES * 10);
        $display("timeout with %0d stats still due", board.pending());
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
src/ulj_pkg.sv
src/ulj_transit.sv
src/ulj_front.sv
src/ulj_accum.sv
src/udp_loss_jitter_tracker.sv
verif/udp_loss_jitter_tracker_test.sv
